>>> design/rmst_pkg.sv
// Package for the range-maximum segment tree: widths, constants, operation, command and state types.
`timescale 1ns / 1ps
package rmst_pkg;
    localparam int LeafCount  = 1024;
    localparam int IndexWidth = $clog2(LeafCount);
    localparam int NodeWidth  = IndexWidth + 1;
    localparam int NodeCount  = 2 * LeafCount;
    localparam int DataWidth  = 32;
    localparam logic signed [DataWidth-1:0] NodeSentinel = -32'sd1000000000;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    // One classified item handed from the front to the back
    typedef struct packed {
        op_t                          op;
        logic                         empty;
        logic [NodeWidth-1:0]         lo;
        logic [NodeWidth-1:0]         hi;
        logic signed [DataWidth-1:0]  value;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_READ,
        ST_UPD_WAIT,
        ST_UPD_WRITE,
        ST_Q_CHECK,
        ST_Q_READ_LO,
        ST_Q_READ_HI,
        ST_Q_WAIT,
        ST_Q_STEP,
        ST_OUT
    } state_t;
endpackage

>>> design/rmst_front.sv
// Front end: accepts items, classifies them and turns leaf indexes into node addresses.
`timescale 1ns / 1ps
module rmst_front import rmst_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);
    cmd_t cmd_reg;
    logic valid_reg;
    cmd_t cmd_next;
    logic [IndexWidth-1:0] left;
    logic [IndexWidth-1:0] right;

    assign s_tready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    // Decode tdata: operation, leaf_index, new_value, range_left, range_right
    always_comb begin
        left           = s_tdata[52:43];
        right          = s_tdata[62:53];
        cmd_next.op    = op_t'(s_tdata[0]);
        cmd_next.value = s_tdata[42:11];
        cmd_next.empty = 1'b0;
        if (cmd_next.op == OP_UPDATE) begin
            cmd_next.lo = {1'b1, s_tdata[10:1]};
            cmd_next.hi = '0;
        end else begin
            cmd_next.lo    = {1'b1, left};
            cmd_next.hi    = {1'b1, right};
            cmd_next.empty = right < left;
        end
    end

    // Output stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            cmd_reg <= cmd_next;
        end
    end
endmodule

>>> design/rmst_back.sv
// Back end: tree memory, clearing pass, update walk and query walk.
`timescale 1ns / 1ps
module rmst_back import rmst_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  cmd_t                        cmd,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic signed [DataWidth-1:0] m_tdata
);
    logic signed [DataWidth-1:0] mem [NodeCount];
    logic signed [DataWidth-1:0] rd_reg;

    state_t state_reg, state_next;
    logic [NodeWidth-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [DataWidth-1:0] acc_reg, acc_next;
    logic pend_hi_reg, pend_hi_next;
    logic [NodeWidth-1:0] rd_addr;
    logic rd_en;
    logic wr_en;
    logic [NodeWidth-1:0] wr_addr;
    logic signed [DataWidth-1:0] wr_data;
    logic [NodeWidth:0] lo_inc;

    // Memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = state_reg == ST_OUT;
    assign m_tdata  = acc_reg;

    // Low end step carries out of the top node, so keep one extra bit
    assign lo_inc = {1'b0, lo_reg} + 1'b1;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        acc_next     = acc_reg;
        pend_hi_next = pend_hi_reg;
        cmd_ready    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = lo_reg;
        wr_data      = NodeSentinel;
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                lo_next = lo_reg + 1'b1;
                if (lo_reg == NodeWidth'(NodeCount - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    lo_next  = cmd.lo;
                    hi_next  = cmd.hi;
                    acc_next = cmd.value;
                    if (cmd.op == OP_UPDATE) begin
                        state_next = ST_UPD_WRITE;
                    end else if (cmd.empty) begin
                        acc_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        acc_next   = NodeSentinel;
                        state_next = ST_Q_CHECK;
                    end
                end
            end
            // Write current node, then read its sibling
            ST_UPD_WRITE: begin
                wr_en   = 1'b1;
                wr_data = acc_reg;
                if (lo_reg == NodeWidth'(1)) state_next = ST_IDLE;
                else state_next = ST_UPD_READ;
            end
            ST_UPD_READ: begin
                rd_en      = 1'b1;
                rd_addr    = lo_reg ^ NodeWidth'(1);
                state_next = ST_UPD_WAIT;
            end
            ST_UPD_WAIT: begin
                if (rd_reg > acc_reg) acc_next = rd_reg;
                lo_next    = lo_reg >> 1;
                state_next = ST_UPD_WRITE;
            end
            ST_Q_CHECK: begin
                if (lo_reg > hi_reg) state_next = ST_OUT;
                else state_next = ST_Q_READ_LO;
            end
            // Read the low end if it is a right child, else the high end if it is a left child
            ST_Q_READ_LO: begin
                pend_hi_next = !hi_reg[0];
                if (lo_reg[0]) begin
                    rd_en      = 1'b1;
                    rd_addr    = lo_reg;
                    state_next = ST_Q_READ_HI;
                end else if (!hi_reg[0]) begin
                    rd_en        = 1'b1;
                    rd_addr      = hi_reg;
                    pend_hi_next = 1'b0;
                    state_next   = ST_Q_WAIT;
                end else begin
                    state_next = ST_Q_STEP;
                end
            end
            ST_Q_READ_HI: begin
                if (rd_reg > acc_reg) acc_next = rd_reg;
                if (pend_hi_reg) begin
                    rd_en        = 1'b1;
                    rd_addr      = hi_reg;
                    pend_hi_next = 1'b0;
                    state_next   = ST_Q_WAIT;
                end else begin
                    state_next = ST_Q_STEP;
                end
            end
            ST_Q_WAIT: begin
                if (rd_reg > acc_reg) acc_next = rd_reg;
                state_next = ST_Q_STEP;
            end
            ST_Q_STEP: begin
                lo_next    = lo_inc[NodeWidth:1];
                hi_next    = (hi_reg - 1'b1) >> 1;
                state_next = (hi_reg == '0) ? ST_OUT : ST_Q_CHECK;
            end
            ST_OUT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            lo_reg    <= '0;
        end else begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
        end
        hi_reg      <= hi_next;
        acc_reg     <= acc_next;
        pend_hi_reg <= pend_hi_next;
    end
endmodule

>>> design/range_max_segment_tree.sv
// Top level of the range-maximum segment tree.
`timescale 1ns / 1ps
// Range-maximum segment tree over 1024 leaves held in one 2048-entry memory.
// After reset a clearing pass writes every node to -1000000000, one per cycle;
// during it the front takes one transfer and then holds s_tready low. An
// update walks from the leaf to the root, writing the node, reading its
// sibling and comparing at each tree level; a query walks both range ends
// per level through the single read port. One item is in the back end at a
// time; one more waits in the front.
module range_max_segment_tree import rmst_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[0], leaf_index[10:1], new_value[42:11], range_left[52:43],
    // range_right[62:53], zero pad [63]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // range_maximum[31:0]
    output logic [31:0] m_tdata
);
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    rmst_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    rmst_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );
endmodule
